/* design/vsc_pkg.sv */
// ----------------------------------------------------------------------------
// vsc_pkg
// Shared types, opcodes and the microcode store for the 8-bit toy CPU core.
// ----------------------------------------------------------------------------
package vsc_pkg;

    localparam logic [7:0] SAT_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_WRITE    = 2'd0,
        MODE_EXEC     = 2'd1,
        MODE_READ_MEM = 2'd2,
        MODE_READ_REG = 2'd3
    } mode_t;

    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_LDI   = 4'd2;
    localparam logic [3:0] OP_STORE = 4'd3;
    localparam logic [3:0] OP_MOVE  = 4'd4;
    localparam logic [3:0] OP_ADD   = 4'd5;
    localparam logic [3:0] OP_JUMP  = 4'd11;
    localparam logic [3:0] OP_HALT  = 4'd12;

    // memory address source
    typedef enum logic [1:0] {MA_PC, MA_PC1, MA_B1, MA_IN} maddr_sel_t;
    // memory write data source
    typedef enum logic {MW_IN, MW_PORT} mwd_sel_t;
    // register file read index
    typedef enum logic [2:0] {RS_R, RS_X, RS_Y, RS_ZERO, RS_IN} rsel_t;
    // register file write index
    typedef enum logic {RW_R, RW_Y} rwa_sel_t;
    // register file write data
    typedef enum logic [1:0] {WD_MEM, WD_B1, WD_PORT, WD_SUM} rwd_sel_t;
    // read-back byte source
    typedef enum logic [1:0] {RV_KEEP, RV_MEM, RV_PORT} rdv_sel_t;
    // sequencing
    typedef enum logic [1:0] {SQ_NEXT, SQ_FIN, SQ_OPDISP, SQ_DONE} seq_t;

    typedef struct packed {
        maddr_sel_t ma;
        logic       mem_we;
        mwd_sel_t   mwd;
        rsel_t      rs;
        logic       a_ld;
        logic       rf_we;
        rwa_sel_t   rwa;
        rwd_sel_t   rwd;
        logic       b0_ld;
        logic       b1_ld;
        logic       pc_inc2;
        logic       jmp_cond;
        logic       store;
        logic       set_halt;
        logic       set_bad;
        rdv_sel_t   rdv;
        logic       out_load;
        seq_t       seq;
    } ucw_t;

    typedef struct packed {
        ucw_t w;
        logic start;
    } seq_ctl_t;

    typedef struct packed {
        logic [3:0] opcode;
        logic       halted;
        logic       out_busy;
    } dp_status_t;

    localparam int UPC_W = 5;

    localparam logic [UPC_W-1:0] UA_WR   = 5'd0;
    localparam logic [UPC_W-1:0] UA_RDM0 = 5'd1;
    localparam logic [UPC_W-1:0] UA_RDM1 = 5'd2;
    localparam logic [UPC_W-1:0] UA_RDR  = 5'd3;
    localparam logic [UPC_W-1:0] UA_EX0  = 5'd4;
    localparam logic [UPC_W-1:0] UA_EX1  = 5'd5;
    localparam logic [UPC_W-1:0] UA_EX2  = 5'd6;
    localparam logic [UPC_W-1:0] UA_LD0  = 5'd7;
    localparam logic [UPC_W-1:0] UA_LD1  = 5'd8;
    localparam logic [UPC_W-1:0] UA_LDI  = 5'd9;
    localparam logic [UPC_W-1:0] UA_ST   = 5'd10;
    localparam logic [UPC_W-1:0] UA_MOV  = 5'd11;
    localparam logic [UPC_W-1:0] UA_ADD0 = 5'd12;
    localparam logic [UPC_W-1:0] UA_ADD1 = 5'd13;
    localparam logic [UPC_W-1:0] UA_JMP0 = 5'd14;
    localparam logic [UPC_W-1:0] UA_JMP1 = 5'd15;
    localparam logic [UPC_W-1:0] UA_HLT  = 5'd16;
    localparam logic [UPC_W-1:0] UA_BAD  = 5'd17;
    localparam logic [UPC_W-1:0] UA_FIN  = 5'd18;

    localparam ucw_t UCW_NOP = '{
        ma:       MA_PC,
        mem_we:   1'b0,
        mwd:      MW_IN,
        rs:       RS_R,
        a_ld:     1'b0,
        rf_we:    1'b0,
        rwa:      RW_R,
        rwd:      WD_MEM,
        b0_ld:    1'b0,
        b1_ld:    1'b0,
        pc_inc2:  1'b0,
        jmp_cond: 1'b0,
        store:    1'b0,
        set_halt: 1'b0,
        set_bad:  1'b0,
        rdv:      RV_KEEP,
        out_load: 1'b0,
        seq:      SQ_NEXT
    };

    // Microcode store. Memory reads land one step after the address is issued.
    function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
        ucw_t w;
        begin
            w = UCW_NOP;
            unique case (upc)
                UA_WR:
                begin
                    w.ma = MA_IN; w.mem_we = 1'b1; w.mwd = MW_IN; w.seq = SQ_FIN;
                end
                UA_RDM0:
                begin
                    w.ma = MA_IN;
                end
                UA_RDM1:
                begin
                    w.rdv = RV_MEM; w.seq = SQ_FIN;
                end
                UA_RDR:
                begin
                    w.rs = RS_IN; w.rdv = RV_PORT; w.seq = SQ_FIN;
                end
                UA_EX0:
                begin
                    w.ma = MA_PC;
                end
                UA_EX1:
                begin
                    w.b0_ld = 1'b1; w.ma = MA_PC1;
                end
                UA_EX2:
                begin
                    w.b1_ld = 1'b1; w.pc_inc2 = 1'b1; w.seq = SQ_OPDISP;
                end
                UA_LD0:
                begin
                    w.ma = MA_B1;
                end
                UA_LD1:
                begin
                    w.rf_we = 1'b1; w.rwa = RW_R; w.rwd = WD_MEM; w.seq = SQ_FIN;
                end
                UA_LDI:
                begin
                    w.rf_we = 1'b1; w.rwa = RW_R; w.rwd = WD_B1; w.seq = SQ_FIN;
                end
                UA_ST:
                begin
                    w.rs = RS_R; w.ma = MA_B1; w.mwd = MW_PORT; w.store = 1'b1;
                    w.seq = SQ_FIN;
                end
                UA_MOV:
                begin
                    w.rs = RS_X; w.rf_we = 1'b1; w.rwa = RW_Y; w.rwd = WD_PORT;
                    w.seq = SQ_FIN;
                end
                UA_ADD0:
                begin
                    w.rs = RS_X; w.a_ld = 1'b1;
                end
                UA_ADD1:
                begin
                    w.rs = RS_Y; w.rf_we = 1'b1; w.rwa = RW_R; w.rwd = WD_SUM;
                    w.seq = SQ_FIN;
                end
                UA_JMP0:
                begin
                    w.rs = RS_R; w.a_ld = 1'b1;
                end
                UA_JMP1:
                begin
                    w.rs = RS_ZERO; w.jmp_cond = 1'b1; w.seq = SQ_FIN;
                end
                UA_HLT:
                begin
                    w.set_halt = 1'b1; w.seq = SQ_FIN;
                end
                UA_BAD:
                begin
                    w.set_halt = 1'b1; w.set_bad = 1'b1; w.seq = SQ_FIN;
                end
                UA_FIN:
                begin
                    w.out_load = 1'b1; w.seq = SQ_DONE;
                end
                default:
                begin
                    w.seq = SQ_FIN;
                end
            endcase
            return w;
        end
    endfunction

endpackage

/* design/vsc_in_if.sv */
// ----------------------------------------------------------------------------
// vsc_in_if
// Request channel: mode, address and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface vsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] address;
    logic [7:0] value;

    modport source (output valid, output mode, output address, output value, input ready);
    modport sink (input valid, input mode, input address, input value, output ready);
endinterface

/* design/vsc_out_if.sv */
// ----------------------------------------------------------------------------
// vsc_out_if
// Result channel: one result per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface vsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;
    logic [7:0] program_counter;
    logic       halted;
    logic       screen_valid;
    logic [7:0] screen_value;
    logic       bad_opcode;

    modport source (
        output valid, output read_value, output program_counter, output halted,
        output screen_valid, output screen_value, output bad_opcode, input ready
    );
    modport sink (
        input valid, input read_value, input program_counter, input halted,
        input screen_valid, input screen_value, input bad_opcode, output ready
    );
endinterface

/* design/vsc_mem.sv */
// ----------------------------------------------------------------------------
// vsc_mem
// 256 x 8 single-port main memory, registered read, reads zero until written.
// ----------------------------------------------------------------------------
module vsc_mem
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] addr,
    input  logic       we,
    input  logic [7:0] wdata,
    output logic [7:0] rdata
);

    logic [7:0] mem_reg [256];
    logic [255:0] vld_reg;
    logic [7:0] rdata_reg;
    logic       rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    // written-entry flags stand in for clearing the array at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[addr] <= 1'b1;
            end
            rvld_reg <= vld_reg[addr];
        end
    end

    assign rdata = rvld_reg ? rdata_reg : 8'd0;

endmodule

/* design/vsc_sequencer.sv */
// ----------------------------------------------------------------------------
// vsc_sequencer
// Micro-PC, control store lookup, entry dispatch and opcode dispatch.
// ----------------------------------------------------------------------------
module vsc_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_mode,
    output logic                  in_ready,
    input  vsc_pkg::dp_status_t   stat,
    output vsc_pkg::seq_ctl_t     ctl
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [vsc_pkg::UPC_W-1:0] upc_reg;
    logic [vsc_pkg::UPC_W-1:0] upc_next;
    logic [vsc_pkg::UPC_W-1:0] entry;
    logic [vsc_pkg::UPC_W-1:0] disp;
    vsc_pkg::ucw_t             word;
    logic                      go;
    logic                      start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= vsc_pkg::UA_FIN;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

    always_comb
    begin
        in_ready = !busy_reg;
        start    = in_valid && !busy_reg;
        word     = vsc_pkg::ucode(upc_reg);
        // the final step waits while the previous result is still unclaimed
        go       = busy_reg && !(word.out_load && stat.out_busy);

        unique case (vsc_pkg::mode_t'(in_mode))
            vsc_pkg::MODE_WRITE:    entry = vsc_pkg::UA_WR;
            vsc_pkg::MODE_READ_MEM: entry = vsc_pkg::UA_RDM0;
            vsc_pkg::MODE_READ_REG: entry = vsc_pkg::UA_RDR;
            vsc_pkg::MODE_EXEC:     entry = stat.halted ? vsc_pkg::UA_FIN : vsc_pkg::UA_EX0;
        endcase

        unique case (stat.opcode)
            vsc_pkg::OP_LOAD:  disp = vsc_pkg::UA_LD0;
            vsc_pkg::OP_LDI:   disp = vsc_pkg::UA_LDI;
            vsc_pkg::OP_STORE: disp = vsc_pkg::UA_ST;
            vsc_pkg::OP_MOVE:  disp = vsc_pkg::UA_MOV;
            vsc_pkg::OP_ADD:   disp = vsc_pkg::UA_ADD0;
            vsc_pkg::OP_JUMP:  disp = vsc_pkg::UA_JMP0;
            vsc_pkg::OP_HALT:  disp = vsc_pkg::UA_HLT;
            default:           disp = vsc_pkg::UA_BAD;
        endcase

        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = entry;
        end
        else if (go)
        begin
            unique case (word.seq)
                vsc_pkg::SQ_NEXT:   upc_next = upc_reg + 1'b1;
                vsc_pkg::SQ_FIN:    upc_next = vsc_pkg::UA_FIN;
                vsc_pkg::SQ_OPDISP: upc_next = disp;
                vsc_pkg::SQ_DONE:   busy_next = 1'b0;
            endcase
        end

        ctl.w     = go ? word : vsc_pkg::UCW_NOP;
        ctl.start = start;
    end

endmodule

/* design/vsc_datapath.sv */
// ----------------------------------------------------------------------------
// vsc_datapath
// Register file, instruction latches, PC, halt flag, memory and result register.
// ----------------------------------------------------------------------------
module vsc_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_address,
    input  logic [7:0]          in_value,
    input  vsc_pkg::seq_ctl_t   ctl,
    output vsc_pkg::dp_status_t stat,
    vsc_out_if.source           result
);

    logic [7:0] rf_reg [16];
    logic [7:0] addr_reg;
    logic [7:0] val_reg;
    logic [7:0] b0_reg;
    logic [7:0] b1_reg;
    logic [7:0] a_reg;
    logic [7:0] pc_reg;
    logic [7:0] pc_next;
    logic       halt_reg;
    logic [7:0] rdv_reg;
    logic [7:0] rdv_next;
    logic       scr_v_reg;
    logic [7:0] scr_reg;
    logic       bad_reg;

    logic       out_valid_reg;
    logic [7:0] out_rdv_reg;
    logic [7:0] out_pc_reg;
    logic       out_halt_reg;
    logic       out_scr_v_reg;
    logic [7:0] out_scr_reg;
    logic       out_bad_reg;

    logic [3:0] rd_idx;
    logic [7:0] port;
    logic [3:0] wr_idx;
    logic [7:0] wr_data;
    logic [8:0] sum;
    logic [7:0] sat;
    logic [7:0] mem_addr;
    logic       mem_we;
    logic [7:0] mem_wdata;
    logic [7:0] mem_q;
    logic       to_screen;
    vsc_pkg::ucw_t w;

    assign w = ctl.w;

    vsc_mem u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    always_comb
    begin
        unique case (w.rs)
            vsc_pkg::RS_R:    rd_idx = b0_reg[3:0];
            vsc_pkg::RS_X:    rd_idx = b1_reg[7:4];
            vsc_pkg::RS_Y:    rd_idx = b1_reg[3:0];
            vsc_pkg::RS_ZERO: rd_idx = 4'd0;
            vsc_pkg::RS_IN:   rd_idx = addr_reg[3:0];
            default:          rd_idx = 4'd0;
        endcase
        port = rf_reg[rd_idx];

        unique case (w.ma)
            vsc_pkg::MA_PC:  mem_addr = pc_reg;
            vsc_pkg::MA_PC1: mem_addr = pc_reg + 8'd1;
            vsc_pkg::MA_B1:  mem_addr = b1_reg;
            vsc_pkg::MA_IN:  mem_addr = addr_reg;
        endcase

        // a store to address zero goes to the screen instead of memory
        to_screen = w.store && (b1_reg == 8'd0);
        mem_we    = w.mem_we || (w.store && (b1_reg != 8'd0));
        mem_wdata = (w.mwd == vsc_pkg::MW_PORT) ? port : val_reg;

        sum = {1'b0, a_reg} + {1'b0, port};
        sat = sum[8] ? vsc_pkg::SAT_MAX : sum[7:0];

        wr_idx = (w.rwa == vsc_pkg::RW_Y) ? b1_reg[3:0] : b0_reg[3:0];
        unique case (w.rwd)
            vsc_pkg::WD_MEM:  wr_data = mem_q;
            vsc_pkg::WD_B1:   wr_data = b1_reg;
            vsc_pkg::WD_PORT: wr_data = port;
            vsc_pkg::WD_SUM:  wr_data = sat;
        endcase

        pc_next = pc_reg;
        if (w.pc_inc2)
        begin
            pc_next = pc_reg + 8'd2;
        end
        else if (w.jmp_cond && (a_reg == port))
        begin
            pc_next = b1_reg;
        end

        unique case (w.rdv)
            vsc_pkg::RV_MEM:  rdv_next = mem_q;
            vsc_pkg::RV_PORT: rdv_next = port;
            default:          rdv_next = rdv_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                rf_reg[i] <= 8'd0;
            end
            pc_reg   <= 8'd0;
            halt_reg <= 1'b0;
        end
        else
        begin
            if (w.rf_we)
            begin
                rf_reg[wr_idx] <= wr_data;
            end
            pc_reg <= pc_next;
            if (w.set_halt)
            begin
                halt_reg <= 1'b1;
            end
        end
    end

    // per-transfer working registers
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            addr_reg  <= in_address;
            val_reg   <= in_value;
            rdv_reg   <= 8'd0;
            scr_v_reg <= 1'b0;
            scr_reg   <= 8'd0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            rdv_reg <= rdv_next;
            if (to_screen)
            begin
                scr_v_reg <= 1'b1;
                scr_reg   <= port;
            end
            if (w.set_bad)
            begin
                bad_reg <= 1'b1;
            end
        end
        if (w.b0_ld)
        begin
            b0_reg <= mem_q;
        end
        if (w.b1_ld)
        begin
            b1_reg <= mem_q;
        end
        if (w.a_ld)
        begin
            a_reg <= port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (w.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w.out_load)
        begin
            out_rdv_reg   <= rdv_reg;
            out_pc_reg    <= pc_reg;
            out_halt_reg  <= halt_reg;
            out_scr_v_reg <= scr_v_reg;
            out_scr_reg   <= scr_reg;
            out_bad_reg   <= bad_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.read_value      = out_rdv_reg;
    assign result.program_counter = out_pc_reg;
    assign result.halted          = out_halt_reg;
    assign result.screen_valid    = out_scr_v_reg;
    assign result.screen_value    = out_scr_reg;
    assign result.bad_opcode      = out_bad_reg;

    assign stat.opcode   = b0_reg[7:4];
    assign stat.halted   = halt_reg;
    assign stat.out_busy = out_valid_reg && !result.ready;

endmodule

/* design/vole_subset_cpu_core.sv */
// ----------------------------------------------------------------------------
// vole_subset_cpu_core
// 8-bit toy CPU with 256-byte memory and sixteen byte registers.
// ----------------------------------------------------------------------------
// Each request transfer writes a memory byte, reads a memory byte or register,
// or executes one instruction, and gives exactly one result transfer. A
// microcoded sequencer steps a small datapath around a single-port memory
// with a registered read. A request runs its microcode steps (for an
// executed instruction, two fetch reads, then one or two operand steps; none
// for an execute while halted) and then a final step that offers the result.
// Ready returns in the cycle the result is first offered, so the next request
// can be taken while that result waits in its output register; a still
// unclaimed result holds the final step. Memory and registers read as zero
// after reset with no clearing pass.
module vole_subset_cpu_core
(
    input  logic      clk,
    input  logic      rst_n,
    vsc_in_if.sink    item,
    vsc_out_if.source result
);

    vsc_pkg::seq_ctl_t   ctl;
    vsc_pkg::dp_status_t stat;

    vsc_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .in_ready (item.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    vsc_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_address (item.address),
        .in_value   (item.value),
        .ctl        (ctl),
        .stat       (stat),
        .result     (result)
    );

    // an accepted request leaves the core busy, not ready, in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("request accepted while previous one in flight");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stat.halted |=> stat.halted)
        else $error("halt flag cleared");

    // a step cannot both output to the screen and fault
    a_screen_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.screen_valid && result.bad_opcode))
        else $error("screen output and bad opcode together");

    // a result is only loaded by the final step of a busy sequence
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(!item.ready))
        else $error("result appeared while idle");

endmodule
